[rtl/core/lea128_block_encrypt_defines.svh]
// assertion macros shared by the lea128 block encrypt rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef LEA128_BLOCK_ENCRYPT_DEFINES_SVH
`define LEA128_BLOCK_ENCRYPT_DEFINES_SVH

// checked at every rising edge, disabled while reset is asserted
`define LEA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lea128 assertion failed");

// checked at every rising edge, reset included
`define LEA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lea128 assertion failed");

`endif

[rtl/core/lea128_pkg.sv]
// shared types, sizes and round-key preset table for the lea128 block encrypt
// no dependencies
`timescale 1ns / 1ps

package lea128_pkg;

  localparam int ROUND_COUNT     = 24;
  localparam int WORDS_PER_ROUND = 4;
  localparam int WORD_W          = 32;
  localparam int SLOT_W          = 7;
  localparam int STORE_DEPTH     = ROUND_COUNT * WORDS_PER_ROUND;
  localparam int ROW_W           = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int SEL_W           = $clog2(WORDS_PER_ROUND);
  localparam int ADDR_W          = ROW_W + SEL_W;
  localparam int IN_DATA_W       = 168;
  localparam int OUT_DATA_W      = WORDS_PER_ROUND * WORD_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORDS_PER_ROUND-1:0] block_t;
  typedef logic [ROW_W-1:0] row_t;

  // controller to datapath and key store
  typedef struct packed {
    logic load_block;
    logic round_en;
    logic load_out;
    logic key_we;
    row_t rd_row;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic word_t swap_bytes(word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // pregenerated round keys, zero past the preset range
  function automatic word_t preset_word(logic [SLOT_W-1:0] idx);
    word_t w;
    case (idx)
      7'd0:  w = 32'h003a0fd4;  7'd1:  w = 32'h02497010;
      7'd2:  w = 32'h194f7db1;  7'd3:  w = 32'h090d0883;
      7'd4:  w = 32'h11fdcbb1;  7'd5:  w = 32'h9e98e0c8;
      7'd6:  w = 32'h18b570cf;  7'd7:  w = 32'h9dc53a79;
      7'd8:  w = 32'hf30f7bb5;  7'd9:  w = 32'h6d6628db;
      7'd10: w = 32'hb74e5dad;  7'd11: w = 32'ha65e46d0;
      7'd12: w = 32'h74120631;  7'd13: w = 32'hdac9bd17;
      7'd14: w = 32'hcd1ecf34;  7'd15: w = 32'h540f76f1;
      7'd16: w = 32'h662147db;  7'd17: w = 32'hc637c47a;
      7'd18: w = 32'h46518932;  7'd19: w = 32'h23269260;
      7'd20: w = 32'he4dd5047;  7'd21: w = 32'hf694285e;
      7'd22: w = 32'he1c2951d;  7'd23: w = 32'h8ca5242c;
      7'd24: w = 32'hbaf8e5ca;  7'd25: w = 32'h3e936cd7;
      7'd26: w = 32'h0fc7e5b1;  7'd27: w = 32'hf1c8fa8c;
      7'd28: w = 32'h5522b80c;  7'd29: w = 32'hee22ca78;
      7'd30: w = 32'h8a6fa8b3;  7'd31: w = 32'h65637b74;
      7'd32: w = 32'h8a19279e;  7'd33: w = 32'h6fb40ffe;
      7'd34: w = 32'h85c5f092;  7'd35: w = 32'h92cc9f25;
      7'd36: w = 32'h9dde584c;  7'd37: w = 32'hcb00c87f;
      7'd38: w = 32'h4780ad66;  7'd39: w = 32'he61b5dcb;
      7'd40: w = 32'h4fa10466;  7'd41: w = 32'hf728e276;
      7'd42: w = 32'hd255411b;  7'd43: w = 32'h656839ad;
      7'd44: w = 32'h9250d058;  7'd45: w = 32'h51bd501f;
      7'd46: w = 32'h1cb40dae;  7'd47: w = 32'h1abf218d;
      7'd48: w = 32'h21dd192d;  7'd49: w = 32'h77c644e2;
      7'd50: w = 32'hcabfaa45;  7'd51: w = 32'h681c207d;
      7'd52: w = 32'hde7ac372;  7'd53: w = 32'h9436afd0;
      7'd54: w = 32'h10331d80;  7'd55: w = 32'hf326fe98;
      7'd56: w = 32'hfb3ac3d4;  7'd57: w = 32'h93df660e;
      7'd58: w = 32'h2f65d8a3;  7'd59: w = 32'hdf92e761;
      7'd60: w = 32'h27620087;  7'd61: w = 32'h265ef76e;
      7'd62: w = 32'h4fb29864;  7'd63: w = 32'h2656ed1a;
      7'd64: w = 32'h227b88ec;  7'd65: w = 32'hd0b3fa6f;
      7'd66: w = 32'hc86a08fd;  7'd67: w = 32'ha864cba9;
      7'd68: w = 32'hf1002361;  7'd69: w = 32'he5e85fc3;
      7'd70: w = 32'h1f0b0408;  7'd71: w = 32'h488e7ac4;
      7'd72: w = 32'hc65415d5;  7'd73: w = 32'h51e176b6;
      7'd74: w = 32'heca88bf9;  7'd75: w = 32'hedb89ece;
      7'd76: w = 32'h9b6fb99c;  7'd77: w = 32'h0548254b;
      7'd78: w = 32'h8de9f7c2;  7'd79: w = 32'hb6b4d146;
      7'd80: w = 32'h7257f134;  7'd81: w = 32'h06051a42;
      7'd82: w = 32'h36bcef01;  7'd83: w = 32'hb649d524;
      7'd84: w = 32'ha540fb03;  7'd85: w = 32'h34b196e6;
      7'd86: w = 32'hf7c80dad;  7'd87: w = 32'h71bc7dc4;
      7'd88: w = 32'h8fbee745;  7'd89: w = 32'hcf744123;
      7'd90: w = 32'h907c0a60;  7'd91: w = 32'h8215ec35;
      7'd92: w = 32'h0bf6adba;  7'd93: w = 32'hdf69029d;
      7'd94: w = 32'h5b72305a;  7'd95: w = 32'hcb47c19f;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/lea128_keys.sv]
// round-key store: one row of four key words per round, per-word valid bits
// depends on lea128_pkg
`timescale 1ns / 1ps

module lea128_keys (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lea128_pkg::cmd_t              cmd_i,
  input  logic [lea128_pkg::ADDR_W-1:0] wr_addr_i,
  input  lea128_pkg::word_t             wr_data_i,
  output lea128_pkg::block_t            key_o
);

  localparam int WPR   = lea128_pkg::WORDS_PER_ROUND;
  localparam int SEL_W = lea128_pkg::SEL_W;

  lea128_pkg::block_t              mem_q [lea128_pkg::ROUND_COUNT];
  logic [lea128_pkg::STORE_DEPTH-1:0] vld_q;
  lea128_pkg::block_t              rd_data_q;
  logic [WPR-1:0]                  rd_vld_q;
  lea128_pkg::row_t                rd_row_q;

  logic [lea128_pkg::ROW_W-1:0] wr_row;
  logic [SEL_W-1:0]             wr_sel;

  assign wr_row = wr_addr_i[lea128_pkg::ADDR_W-1:SEL_W];
  assign wr_sel = wr_addr_i[SEL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_we) begin
      mem_q[wr_row][wr_sel] <= wr_data_i;
    end
    rd_data_q <= mem_q[cmd_i.rd_row];
    rd_row_q  <= cmd_i.rd_row;
  end

  // never-written words fall back to the preset table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      if (cmd_i.key_we) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[{cmd_i.rd_row, {SEL_W{1'b0}}} +: WPR];
    end
  end

  always_comb begin
    for (int j = 0; j < WPR; j++) begin
      key_o[j] = rd_vld_q[j] ? rd_data_q[j]
               : lea128_pkg::preset_word(lea128_pkg::SLOT_W'({rd_row_q, SEL_W'(j)}));
    end
  end

endmodule

[rtl/core/lea128_dp.sv]
// datapath: block state, one shared round unit and the output register
// depends on lea128_pkg
`timescale 1ns / 1ps

module lea128_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lea128_pkg::cmd_t     cmd_i,
  output lea128_pkg::sts_t     sts_o,
  input  lea128_pkg::block_t   blk_i,
  input  lea128_pkg::block_t   key_i,
  output lea128_pkg::block_t   out_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  lea128_pkg::block_t x_q, x_d;
  lea128_pkg::block_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  lea128_pkg::word_t s0, s1, s2;

  assign s0 = (x_q[0] ^ key_i[0]) + (x_q[1] ^ key_i[1]);
  assign s1 = (x_q[1] ^ key_i[2]) + (x_q[2] ^ key_i[1]);
  assign s2 = (x_q[2] ^ key_i[3]) + (x_q[3] ^ key_i[1]);

  always_comb begin
    x_d = x_q;
    if (cmd_i.load_block) begin
      for (int j = 0; j < lea128_pkg::WORDS_PER_ROUND; j++) begin
        x_d[j] = lea128_pkg::swap_bytes(blk_i[j]);
      end
    end else if (cmd_i.round_en) begin
      x_d[0] = {s0[22:0], s0[31:23]};
      x_d[1] = {s1[4:0], s1[31:5]};
      x_d[2] = {s2[2:0], s2[31:3]};
      x_d[3] = x_q[0];
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      for (int j = 0; j < lea128_pkg::WORDS_PER_ROUND; j++) begin
        out_d[j] = lea128_pkg::swap_bytes(x_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_o          = out_q;
  assign out_valid_o    = out_valid_q;

endmodule

[rtl/core/lea128_ctrl.sv]
// controller: accepts items, sequences the rounds, hands off the result
// depends on lea128_pkg and lea128_block_encrypt_defines.svh
`timescale 1ns / 1ps
`include "lea128_block_encrypt_defines.svh"

module lea128_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [lea128_pkg::SLOT_W-1:0] key_slot_i,
  input  lea128_pkg::sts_t              sts_i,
  output lea128_pkg::cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam int CMP_W = lea128_pkg::SLOT_W + 1;

  state_e           state_q, state_d;
  lea128_pkg::row_t cnt_q, cnt_d;
  logic             accept;
  logic             last;
  logic             slot_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == lea128_pkg::ROW_W'(lea128_pkg::ROUND_COUNT - 1));
  assign slot_ok    = CMP_W'(key_slot_i) < CMP_W'(lea128_pkg::STORE_DEPTH);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && mode_i) begin
          cmd_o.key_we = slot_ok;
        end else if (accept) begin
          cmd_o.load_block = 1'b1;
          state_d          = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.round_en = 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d        = cnt_q + 1'b1;
          cmd_o.rd_row = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `LEA_ASSERT(a_last_round_done, (state_q == ST_RUN && last) |=> (state_q == ST_DONE))
  `LEA_ASSERT(a_start_at_round0, cmd_o.load_block |=> (state_q == ST_RUN && cnt_q == '0))
  `LEA_ASSERT(a_load_out_free, cmd_o.load_out |-> sts_i.out_free)
  `LEA_ASSERT_ALWAYS(a_key_we_idle, cmd_o.key_we |-> (accept && mode_i))

endmodule

[rtl/core/lea128_block_encrypt.sv]
// top level of the lea128 block encrypt: stream ports, controller, key store, datapath
// depends on lea128_pkg, lea128_ctrl, lea128_keys and lea128_dp
`timescale 1ns / 1ps

// lea-128 encryption of one 128-bit block per item over 24 rounds, with a
// writable 96-word round-key store that comes out of reset holding the
// pregenerated round keys. s_axis_tuser_i selects the item kind: 0 encrypts
// the four block words, 1 writes key_value into round-key word key_slot
// (slots past the store depth are dropped) and gives no result. for an
// encrypt item the accepting edge loads the block and fetches the first
// key row, then the rounds run one per cycle on the single shared round
// unit, which reads one 4-word key row per cycle from the key store, and
// the result moves into the output register once the output is free. a
// key write goes into the store at the edge that accepts it. the next item
// is taken as soon as the previous one has moved into the output register,
// even while that result still waits on m_axis_tready_i; a result that
// cannot be handed over holds the round unit until the output frees up.
// words are byte-swapped on entry and again on exit

module lea128_block_encrypt (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input item stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // block_word_0 [31:0], block_word_1 [63:32], block_word_2 [95:64],
  // block_word_3 [127:96], key_slot [134:128], key_value [166:135], zero [167]
  input  logic [167:0] s_axis_tdata_i,
  // mode [0]
  input  logic         s_axis_tuser_i,
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cipher_word_0 [31:0], cipher_word_1 [63:32], cipher_word_2 [95:64],
  // cipher_word_3 [127:96]
  output logic [127:0] m_axis_tdata_o
);

  localparam int BLK_W = lea128_pkg::OUT_DATA_W;

  lea128_pkg::cmd_t   cmd;
  lea128_pkg::sts_t   sts;
  lea128_pkg::block_t blk;
  lea128_pkg::block_t key;
  lea128_pkg::block_t out_blk;

  logic [lea128_pkg::SLOT_W-1:0] key_slot;
  lea128_pkg::word_t             key_value;

  // unpack the input item
  assign blk       = s_axis_tdata_i[BLK_W-1:0];
  assign key_slot  = s_axis_tdata_i[BLK_W +: lea128_pkg::SLOT_W];
  assign key_value = s_axis_tdata_i[BLK_W + lea128_pkg::SLOT_W +: lea128_pkg::WORD_W];

  // fsm: item acceptance, round count, output handoff
  lea128_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .mode_i     (s_axis_tuser_i),
    .key_slot_i (key_slot),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // round-key rows, one row read per cycle
  lea128_keys u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (key_slot[lea128_pkg::ADDR_W-1:0]),
    .wr_data_i (key_value),
    .key_o     (key)
  );

  // block state, round unit and output register
  lea128_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .blk_i       (blk),
    .key_i       (key),
    .out_o       (out_blk),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_blk;

endmodule
